// File: design/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg: shared types, constants and arithmetic helpers
// delay-line tables, register codes and fixed-point helpers for the reverb
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int PREDELAY_LEN   = 960;
    localparam int COMB_COUNT     = 8;
    localparam int ALLPASS_COUNT  = 4;
    localparam int COMB_MEM_DEPTH = 42054;
    localparam int AP_MEM_DEPTH   = 4698;

    localparam logic [14:0] UNITY_Q14 = 15'd16384;

    typedef logic signed [47:0] t_prod;

    // register indexes of the config port
    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_DAMP   = 3'd1;
    localparam logic [2:0] CFG_WET    = 3'd2;
    localparam logic [2:0] CFG_DRY    = 3'd3;
    localparam logic [2:0] CFG_APG    = 3'd4;
    localparam logic [2:0] CFG_MASTER = 3'd5;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic               block_end;
    } t_in;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               block_end_out;
    } t_out;

    typedef struct packed {
        logic        enable;
        logic [14:0] damp;
        logic [15:0] wet;
        logic [15:0] dry;
        logic [13:0] apg;
        logic [15:0] master;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        logic ready;
        logic done;
    } t_lane_sts;

    // per channel line bases and lengths, left row first
    localparam logic [15:0] COMB_BASE [2][8] = '{
        '{16'd0, 16'd509, 16'd1372, 16'd2853, 16'd5374, 16'd9647, 16'd16900, 16'd26907},
        '{16'd0, 16'd523, 16'd1400, 16'd2889, 16'd5420, 16'd9703, 16'd16986, 16'd27023}};
    localparam logic [13:0] COMB_LEN [2][8] = '{
        '{14'd509, 14'd863, 14'd1481, 14'd2521, 14'd4273, 14'd7253, 14'd10007, 14'd15013},
        '{14'd523, 14'd877, 14'd1489, 14'd2531, 14'd4283, 14'd7283, 14'd10037, 14'd15031}};
    localparam logic [15:0] COMB_FB [2][8] = '{
        '{16'd48891, 16'd43320, 16'd38466, 16'd41642,
          16'd48189, 16'd55072, 16'd56746, 16'd58825},
        '{16'd48499, 16'd43030, 16'd38355, 16'd41567,
          16'd48154, 16'd55032, 16'd56722, 16'd58818}};
    localparam logic [15:0] COMB_WT [8] = '{
        16'd40632, 16'd39322, 16'd38011, 16'd36045,
        16'd34079, 16'd32768, 16'd31457, 16'd29491};
    localparam logic [12:0] AP_BASE [2][4] = '{
        '{13'd0, 13'd142, 13'd538, 13'd1609},
        '{13'd0, 13'd145, 13'd544, 13'd1617}};
    localparam logic [11:0] AP_LEN [2][4] = '{
        '{12'd142, 12'd396, 12'd1071, 12'd3079},
        '{12'd145, 12'd399, 12'd1073, 12'd3081}};

    // signed times unsigned coefficient
    function automatic t_prod mulsu(logic signed [23:0] a, logic [16:0] b);
        return t_prod'(a) * t_prod'($signed({1'b0, b}));
    endfunction

    // round half up then shift
    function automatic t_prod rsh(t_prod v, int unsigned s);
        t_prod t;
        t = v + (t_prod'(1) <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic signed [23:0] sat24(t_prod v);
        if (v > 48'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -48'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [15:0] sat16(t_prod v);
        if (v > 48'sd32767) begin
            return 16'sd32767;
        end else if (v < -48'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

endpackage

// File: design/scr_lane.sv
// ----------------------------------------------------------------------------
// scr_lane: one channel of the reverb
// predelay, eight damped combs, four allpasses and the mix, on one multiplier
// ----------------------------------------------------------------------------
module scr_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_chan,
    input  scr_pkg::t_lane_ctl i_ctl,
    input  scr_pkg::t_cfg      i_cfg,
    input  logic signed [15:0] i_sample,
    output scr_pkg::t_lane_sts o_sts,
    output logic signed [15:0] o_result
);
    import scr_pkg::*;

    typedef enum logic [18:0] {
        S_CLEAR = 19'b0000000000000000001,
        S_IDLE  = 19'b0000000000000000010,
        S_PRE   = 19'b0000000000000000100,
        S_CRD   = 19'b0000000000000001000,
        S_CF    = 19'b0000000000000010000,
        S_CW    = 19'b0000000000000100000,
        S_CL1   = 19'b0000000000001000000,
        S_CL2   = 19'b0000000000010000000,
        S_CSUM  = 19'b0000000000100000000,
        S_ARD   = 19'b0000000001000000000,
        S_AG    = 19'b0000000010000000000,
        S_AY    = 19'b0000000100000000000,
        S_AM    = 19'b0000001000000000000,
        S_AW    = 19'b0000010000000000000,
        S_M1    = 19'b0000100000000000000,
        S_M2    = 19'b0001000000000000000,
        S_M3    = 19'b0010000000000000000,
        S_M4    = 19'b0100000000000000000,
        S_DONE  = 19'b1000000000000000000
    } t_state;

    t_state r_state, n_state;

    logic signed [15:0] pre_mem  [PREDELAY_LEN];
    logic signed [23:0] comb_mem [COMB_MEM_DEPTH];
    logic signed [23:0] ap_mem   [AP_MEM_DEPTH];

    logic [15:0]        r_clr;
    logic [2:0]         r_idx;
    logic [9:0]         r_ppos;
    logic [13:0]        r_cpos [COMB_COUNT];
    logic [11:0]        r_apos [ALLPASS_COUNT];
    logic signed [23:0] r_lp   [COMB_COUNT];

    logic signed [15:0] r_sample, r_prd, r_res;
    logic signed [23:0] r_crd, r_ard, r_x, r_f, r_wet, r_y;
    t_prod              r_prod, r_wprod, r_acc;

    logic               clearing;
    logic [1:0]         aidx;
    logic [15:0]        caddr;
    logic [12:0]        aaddr;
    logic [9:0]         paddr;
    logic               c_we, a_we, p_we;
    logic signed [23:0] c_wd, a_wd, lp_new;
    logic signed [15:0] p_wd;
    logic [14:0]        d_eff, one_m;
    logic [13:0]        cpos_nx;
    logic [11:0]        apos_nx;
    logic               last_c, last_a, clr_last;
    t_prod              f_full;

    always_comb begin
        clearing = (r_state == S_CLEAR);
        aidx     = r_idx[1:0];
        d_eff    = (i_cfg.damp > UNITY_Q14) ? UNITY_Q14 : i_cfg.damp;
        one_m    = UNITY_Q14 - d_eff;
        // feedback product fits 24 bits since every feedback is below one
        f_full   = rsh(r_prod, 16);
        lp_new   = sat24(rsh(r_prod + mulsu(r_f, 17'(d_eff)), 14));
        cpos_nx  = (r_cpos[r_idx] + 14'd1 >= COMB_LEN[i_chan][r_idx]) ? 14'd0
                 : r_cpos[r_idx] + 14'd1;
        apos_nx  = (r_apos[aidx] + 12'd1 >= AP_LEN[i_chan][aidx]) ? 12'd0
                 : r_apos[aidx] + 12'd1;
        last_c   = (r_idx == 3'(COMB_COUNT - 1));
        last_a   = (aidx == 2'(ALLPASS_COUNT - 1));
        clr_last = (r_clr == 16'(COMB_MEM_DEPTH - 1));

        caddr = clearing ? r_clr : COMB_BASE[i_chan][r_idx] + 16'(r_cpos[r_idx]);
        aaddr = clearing ? r_clr[12:0] : AP_BASE[i_chan][aidx] + 13'(r_apos[aidx]);
        paddr = clearing ? r_clr[9:0] : r_ppos;
        c_we  = clearing || (r_state == S_CL2);
        a_we  = (clearing && (r_clr < 16'(AP_MEM_DEPTH))) || (r_state == S_AW);
        p_we  = (clearing && (r_clr < 16'(PREDELAY_LEN))) || (r_state == S_PRE);
        c_wd  = clearing ? 24'sd0 : sat24(t_prod'(r_prd) + t_prod'(lp_new));
        a_wd  = clearing ? 24'sd0 : sat24(t_prod'(r_wet) + rsh(r_prod, 14));
        p_wd  = clearing ? 16'sd0 : r_sample;
    end

    // delay memories, read before write at the same address
    always_ff @(posedge i_clk) begin
        if (r_state == S_PRE) begin
            r_prd <= pre_mem[paddr];
        end
        if (p_we) begin
            pre_mem[paddr] <= p_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CRD) begin
            r_crd <= comb_mem[caddr];
        end
        if (c_we) begin
            comb_mem[caddr] <= c_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ARD) begin
            r_ard <= ap_mem[aaddr];
        end
        if (a_we) begin
            ap_mem[aaddr] <= a_wd;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: n_state = clr_last ? S_IDLE : S_CLEAR;
            S_IDLE:  n_state = i_ctl.start ? S_PRE : S_IDLE;
            S_PRE:   n_state = S_CRD;
            S_CRD:   n_state = S_CF;
            S_CF:    n_state = S_CW;
            S_CW:    n_state = S_CL1;
            S_CL1:   n_state = S_CL2;
            S_CL2:   n_state = last_c ? S_CSUM : S_CRD;
            S_CSUM:  n_state = S_ARD;
            S_ARD:   n_state = S_AG;
            S_AG:    n_state = S_AY;
            S_AY:    n_state = S_AM;
            S_AM:    n_state = S_AW;
            S_AW:    n_state = last_a ? S_M1 : S_ARD;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_DONE;
            S_DONE:  n_state = i_ctl.ack ? S_IDLE : S_DONE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_idx   <= '0;
            r_ppos  <= '0;
            for (int k = 0; k < COMB_COUNT; k++) begin
                r_cpos[k] <= '0;
                r_lp[k]   <= '0;
            end
            for (int k = 0; k < ALLPASS_COUNT; k++) begin
                r_apos[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 16'd1;
                S_IDLE: begin
                    r_sample <= i_sample;
                    r_idx    <= '0;
                    r_acc    <= '0;
                end
                S_PRE: begin
                    r_ppos <= (r_ppos == 10'(PREDELAY_LEN - 1)) ? 10'd0 : r_ppos + 10'd1;
                end
                S_CRD: begin
                end
                S_CF: begin
                    r_x    <= r_crd;
                    r_prod <= mulsu(r_crd, 17'(COMB_FB[i_chan][r_idx]));
                end
                S_CW: begin
                    r_f     <= f_full[23:0];
                    r_wprod <= mulsu(r_x, 17'(COMB_WT[r_idx]));
                end
                S_CL1: begin
                    r_acc  <= r_acc + r_wprod;
                    r_prod <= mulsu(r_lp[r_idx], 17'(one_m));
                end
                S_CL2: begin
                    r_lp[r_idx]   <= lp_new;
                    r_cpos[r_idx] <= cpos_nx;
                    r_idx         <= last_c ? 3'd0 : r_idx + 3'd1;
                end
                S_CSUM: r_wet <= sat24(rsh(r_acc, 16));
                S_ARD: begin
                end
                S_AG:  r_prod <= mulsu(r_wet, 17'(i_cfg.apg));
                S_AY:  r_y <= sat24(t_prod'(r_ard) - rsh(r_prod, 14));
                S_AM:  r_prod <= mulsu(r_y, 17'(i_cfg.apg));
                S_AW: begin
                    r_wet        <= r_y;
                    r_apos[aidx] <= apos_nx;
                    r_idx        <= last_a ? 3'd0 : r_idx + 3'd1;
                end
                S_M1:  r_prod <= mulsu(24'(r_sample), 17'(i_cfg.dry));
                S_M2:  r_prod <= r_prod + mulsu(r_wet, 17'(i_cfg.wet));
                S_M3:  r_prod <= mulsu(sat24(rsh(r_prod, 14)), 17'(i_cfg.master));
                S_M4:  r_res <= sat16(rsh(r_prod, 14));
                S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.ready = (r_state == S_IDLE);
    assign o_sts.done  = (r_state == S_DONE);
    assign o_result    = r_res;

endmodule

// File: design/stereo_comb_allpass_reverb.sv
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb: stereo comb and allpass reverb
// two channel lanes run side by side; the output stage merges their results
// ----------------------------------------------------------------------------
// a new word is taken only once the previous one is in the output register;
//   each lane's single multiplier steps through eight combs, four allpasses
//   and the mix for each enabled word, while a bypassed word skips the lanes
// reset: synchronous; a clearing pass after it zeroes the delay memories,
//   during which no word is taken; config writes are taken throughout
module stereo_comb_allpass_reverb (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  scr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output scr_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);
    import scr_pkg::*;

    // config registers
    t_cfg r_cfg;

    // control of the word in work
    logic r_busy;
    logic r_byp;
    logic r_blk;
    t_in  r_dry;

    // output register
    logic r_out_valid;
    t_out r_out;

    t_lane_ctl ctl;
    t_lane_sts sts_l, sts_r;
    logic signed [15:0] res_l, res_r;

    logic in_acc, res_rdy, load, out_take;

    always_comb begin
        in_acc    = i_in_valid && !o_in_stall;
        // both lanes finish together; a result is ready when both report done or the word is bypassed
        res_rdy   = r_busy && (r_byp || (sts_l.done && sts_r.done));
        out_take  = r_out_valid && !i_out_stall;
        load      = res_rdy && (!r_out_valid || out_take);
        ctl.start = in_acc && r_cfg.enable;
        ctl.ack   = load && !r_byp;
    end

    // new word only when no word is in work and both lanes are idle
    assign o_in_stall = r_busy || !sts_l.ready || !sts_r.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b1;
            r_cfg.damp   <= 15'd6554;
            r_cfg.wet    <= 16'd8192;
            r_cfg.dry    <= 16'd8192;
            r_cfg.apg    <= 14'd8192;
            r_cfg.master <= 16'd24576;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                CFG_DAMP:   r_cfg.damp   <= i_cfg_data[14:0];
                CFG_WET:    r_cfg.wet    <= i_cfg_data;
                CFG_DRY:    r_cfg.dry    <= i_cfg_data;
                CFG_APG:    r_cfg.apg    <= i_cfg_data[13:0];
                CFG_MASTER: r_cfg.master <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_byp  <= !r_cfg.enable;
            end else if (load) begin
                r_busy <= 1'b0;
                r_byp  <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload capture, and merge of the two lane results or the bypassed dry word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dry <= i_in_data;
            r_blk <= i_in_data.block_end;
        end
        if (load) begin
            r_out.left_out      <= r_byp ? r_dry.left_in : res_l;
            r_out.right_out     <= r_byp ? r_dry.right_in : res_r;
            r_out.block_end_out <= r_blk;
        end
    end

    scr_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_chan   (1'b0),
        .i_ctl    (ctl),
        .i_cfg    (r_cfg),
        .i_sample (i_in_data.left_in),
        .o_sts    (sts_l),
        .o_result (res_l)
    );

    scr_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_chan   (1'b1),
        .i_ctl    (ctl),
        .i_cfg    (r_cfg),
        .i_sample (i_in_data.right_in),
        .o_sts    (sts_r),
        .o_result (res_r)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // lanes run the same schedule and must stay in step
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sts_l.done == sts_r.done) && (sts_l.ready == sts_r.ready))
        else $error("lanes out of step");

    // a lane start only ever hits idle lanes
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |-> (sts_l.ready && sts_r.ready))
        else $error("lane started while busy");

    // a bypassed word never has lane work pending
    a_byp_no_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_byp) |-> (!sts_l.done && sts_l.ready))
        else $error("bypass overlaps lane work");

    // an accepted word always leaves the block busy in the next cycle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy)
        else $error("accepted word lost");
`endif

endmodule
